FILE: sv/ppms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppms_pkg
// shared types, constants and the control program of the predator-prey map core
// ----------------------------------------------------------------------------
package ppms_pkg;

    // default datapath shape
    localparam int WORD_WIDTH_DEF = 48;
    localparam int FRAC_BITS_DEF  = 32;

    // register reset values (raw fixed point bit patterns)
    localparam logic [63:0] GROWTH_RESET      = 64'd171798692;
    localparam logic [63:0] INTERACTION_RESET = 64'd2147484;
    localparam logic [63:0] DEATH_RESET       = 64'd858993459;
    localparam logic [63:0] CONVERSION_RESET  = 64'd429496730;
    localparam logic [63:0] PREY_START_RESET  = 64'd429496730;
    localparam logic [63:0] PRED_START_RESET  = 64'd429496730;

    // configuration register indexes
    localparam int          CFG_IDX_W      = 3;
    localparam logic [2:0]  CFG_GROWTH     = 3'd0;
    localparam logic [2:0]  CFG_INTERACT   = 3'd1;
    localparam logic [2:0]  CFG_DEATH      = 3'd2;
    localparam logic [2:0]  CFG_CONVERSION = 3'd3;
    localparam logic [2:0]  CFG_PREY_START = 3'd4;
    localparam logic [2:0]  CFG_PRED_START = 3'd5;

    // item kinds
    localparam logic [1:0]  KIND_STEP        = 2'd0;
    localparam logic [1:0]  KIND_LOAD_START  = 2'd1;
    localparam logic [1:0]  KIND_LOAD_CARRY  = 2'd2;

    // sequencer
    localparam int PC_W = 5;

    typedef enum logic
    {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic [2:0]
    {
        OP_LOAD,
        OP_PART,
        OP_FIN,
        OP_SUM_PREY,
        OP_SUM_PRED,
        OP_DONE
    } op_t;

    typedef enum logic [2:0]
    {
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_E,
        SRC_PREY,
        SRC_PRED,
        SRC_PP,
        SRC_BPP
    } src_t;

    typedef enum logic [2:0]
    {
        DST_AR,
        DST_PP,
        DST_BPP,
        DST_EBPP,
        DST_CF
    } dst_t;

    typedef struct packed
    {
        op_t             op;
        src_t            src_x;
        src_t            src_y;
        dst_t            dst;
        logic            loop;
        logic [PC_W-1:0] target;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c.op     = OP_DONE;
        c.src_x  = SRC_A;
        c.src_y  = SRC_PREY;
        c.dst    = DST_AR;
        c.loop   = 1'b0;
        c.target = pc;
        case (pc)
            // a * prey
            5'd0:  begin c.op = OP_LOAD; c.src_x = SRC_A; c.src_y = SRC_PREY; end
            5'd1:  begin c.op = OP_PART; c.loop = 1'b1; end
            5'd2:  begin c.op = OP_FIN;  c.dst = DST_AR; end
            // prey * pred
            5'd3:  begin c.op = OP_LOAD; c.src_x = SRC_PREY; c.src_y = SRC_PRED; end
            5'd4:  begin c.op = OP_PART; c.loop = 1'b1; end
            5'd5:  begin c.op = OP_FIN;  c.dst = DST_PP; end
            // b * pp
            5'd6:  begin c.op = OP_LOAD; c.src_x = SRC_B; c.src_y = SRC_PP; end
            5'd7:  begin c.op = OP_PART; c.loop = 1'b1; end
            5'd8:  begin c.op = OP_FIN;  c.dst = DST_BPP; end
            // e * bpp
            5'd9:  begin c.op = OP_LOAD; c.src_x = SRC_E; c.src_y = SRC_BPP; end
            5'd10: begin c.op = OP_PART; c.loop = 1'b1; end
            5'd11: begin c.op = OP_FIN;  c.dst = DST_EBPP; end
            // c * pred
            5'd12: begin c.op = OP_LOAD; c.src_x = SRC_C; c.src_y = SRC_PRED; end
            5'd13: begin c.op = OP_PART; c.loop = 1'b1; end
            5'd14: begin c.op = OP_FIN;  c.dst = DST_CF; end
            // new pair
            5'd15: c.op = OP_SUM_PREY;
            5'd16: c.op = OP_SUM_PRED;
            default: c.op = OP_DONE;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/predator_prey_map_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// predator_prey_map_step_core
// one step of the discrete predator-prey map in saturating signed fixed point
// ----------------------------------------------------------------------------
//
//  channel | signals                              | beat carries
//  --------+--------------------------------------+--------------------------------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write, index 0..5
//  s       | s_tvalid s_tready s_tdata s_tuser    | kind, prey_load, predator_load
//  m       | m_tvalid m_tready m_tdata m_tuser    | prey_out, predator_out, saturated
//
//  a step beat runs the accept step, then five products (operand load, four
//  half-width partial products through one shared multiplier, shift and
//  clamp), then the prey sum, the predator sum and the write-back step.
//  load beats and unused kinds leave the sequencer idle and give no result.
//  reset loads the rates, the start values and the pair; no clearing pass.
//  a finished result waits in the output register; only the write-back step of
//  the next step beat stalls on it, so input beats are still accepted meanwhile.
//
module predator_prey_map_step_core
#(
    parameter int WORD_WIDTH = ppms_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = ppms_pkg::FRAC_BITS_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,

    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [ppms_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [WORD_WIDTH-1:0]                    cfg_data,

    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // prey_load, predator_load, zero fill
    input  logic [((2*WORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    // kind
    input  logic [1:0]                               s_tuser,

    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // prey_out, predator_out, zero fill
    output logic [((2*WORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    // saturated
    output logic                                     m_tuser
);

    localparam int W       = WORD_WIDTH;
    localparam int H       = (WORD_WIDTH + 1) / 2;   // multiplier half width
    localparam int AW      = 4 * H;                  // product accumulator width
    localparam int TDATA_W = ((2*WORD_WIDTH+7)/8)*8;

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    ppms_pkg::seq_state_t      state_reg, state_next;
    logic [ppms_pkg::PC_W-1:0] pc_reg, pc_next;

    // configuration
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] c_reg, c_next;
    logic [W-1:0] e_reg, e_next;
    logic [W-1:0] prey0_reg, prey0_next;
    logic [W-1:0] pred0_reg, pred0_next;

    // map state
    logic [W-1:0] prey_reg, prey_next;
    logic [W-1:0] pred_reg, pred_next;

    // step temporaries
    logic [W-1:0] ar_reg, ar_next;
    logic [W-1:0] pp_reg, pp_next;
    logic [W-1:0] bpp_reg, bpp_next;
    logic [W-1:0] ebpp_reg, ebpp_next;
    logic [W-1:0] cf_reg, cf_next;
    logic [W-1:0] nprey_reg, nprey_next;
    logic [W-1:0] npred_reg, npred_next;
    logic         sat_reg, sat_next;

    // shared multiplier
    logic [2*H-1:0]        mx_reg, mx_next;
    logic [2*H-1:0]        my_reg, my_next;
    logic                  mneg_reg, mneg_next;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic [1:0]            part_reg, part_next;

    // output register
    logic         ovalid_reg, ovalid_next;
    logic [W-1:0] oprey_reg, oprey_next;
    logic [W-1:0] opred_reg, opred_next;
    logic         osat_reg, osat_next;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    ppms_pkg::ctrl_t ctrl;
    logic            in_beat;
    logic            step_beat;
    logic            out_free;
    logic            running;

    assign ctrl      = ppms_pkg::ucode(pc_reg);
    assign in_beat   = s_tvalid && s_tready;
    assign step_beat = in_beat && (s_tuser == ppms_pkg::KIND_STEP);
    // output register can take a new result this cycle
    assign out_free  = !ovalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppms_pkg::SEQ_IDLE:
            begin
                if (step_beat)
                begin
                    state_next = ppms_pkg::SEQ_RUN;
                end
            end
            ppms_pkg::SEQ_RUN:
            begin
                if (ctrl.op == ppms_pkg::OP_DONE && out_free)
                begin
                    state_next = ppms_pkg::SEQ_IDLE;
                end
            end
            default: state_next = ppms_pkg::SEQ_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        running  = 1'b0;
        unique case (state_reg)
            ppms_pkg::SEQ_IDLE: s_tready = 1'b1;
            ppms_pkg::SEQ_RUN:  running  = 1'b1;
            default:
            begin
                s_tready = 1'b0;
                running  = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    logic [W-1:0]         sel_x, sel_y;
    logic [W-1:0]         mag_x, mag_y;
    logic [H-1:0]         half_x, half_y;
    logic [2*H-1:0]       half_prod;
    logic [AW-1:0]        prod_ext;
    logic [AW-1:0]        prod_sh;
    logic signed [AW-1:0] acc_sar;
    logic                 prod_ok;
    logic [W-1:0]         prod_clamped;
    logic [W-1:0]         sum_x, sum_y, sum_z;
    logic [W+1:0]         sum_full;
    logic                 sum_ok;
    logic [W-1:0]         sum_clamped;

    function automatic logic [W-1:0] pick(input ppms_pkg::src_t s,
                                          input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] c, input logic [W-1:0] e,
                                          input logic [W-1:0] prey, input logic [W-1:0] pred,
                                          input logic [W-1:0] pp, input logic [W-1:0] bpp);
        logic [W-1:0] r;
        r = a;
        unique case (s)
            ppms_pkg::SRC_A:    r = a;
            ppms_pkg::SRC_B:    r = b;
            ppms_pkg::SRC_C:    r = c;
            ppms_pkg::SRC_E:    r = e;
            ppms_pkg::SRC_PREY: r = prey;
            ppms_pkg::SRC_PRED: r = pred;
            ppms_pkg::SRC_PP:   r = pp;
            ppms_pkg::SRC_BPP:  r = bpp;
            default:            r = a;
        endcase
        return r;
    endfunction

    always_comb
    begin
        sel_x = pick(ctrl.src_x, a_reg, b_reg, c_reg, e_reg,
                     prey_reg, pred_reg, pp_reg, bpp_reg);
        sel_y = pick(ctrl.src_y, a_reg, b_reg, c_reg, e_reg,
                     prey_reg, pred_reg, pp_reg, bpp_reg);
        // magnitudes; the most negative word maps to 2^(W-1) unsigned
        mag_x = sel_x[W-1] ? (~sel_x + 1'b1) : sel_x;
        mag_y = sel_y[W-1] ? (~sel_y + 1'b1) : sel_y;
    end

    // one half-width partial product per cycle: part[0] picks the half of x,
    // part[1] the half of y
    always_comb
    begin
        half_x    = part_reg[0] ? mx_reg[2*H-1:H] : mx_reg[H-1:0];
        half_y    = part_reg[1] ? my_reg[2*H-1:H] : my_reg[H-1:0];
        half_prod = half_x * half_y;
        prod_ext  = AW'(half_prod);
        case (part_reg)
            2'd0:    prod_sh = prod_ext;
            2'd1:    prod_sh = prod_ext << H;
            2'd2:    prod_sh = prod_ext << H;
            default: prod_sh = prod_ext << (2*H);
        endcase
    end

    // drop fraction bits (floor) and clamp to the word
    always_comb
    begin
        acc_sar      = acc_reg >>> FRAC_BITS;
        prod_ok      = (&acc_sar[AW-1:W-1]) || !(|acc_sar[AW-1:W-1]);
        prod_clamped = prod_ok ? acc_sar[W-1:0] : (acc_reg[AW-1] ? WMIN : WMAX);
    end

    // three-term sum with one clamp
    always_comb
    begin
        if (ctrl.op == ppms_pkg::OP_SUM_PRED)
        begin
            sum_x = pred_reg;
            sum_y = ebpp_reg;
            sum_z = cf_reg;
        end
        else
        begin
            sum_x = prey_reg;
            sum_y = ar_reg;
            sum_z = bpp_reg;
        end
        sum_full = {{2{sum_x[W-1]}}, sum_x} + {{2{sum_y[W-1]}}, sum_y}
                 - {{2{sum_z[W-1]}}, sum_z};
        sum_ok      = (&sum_full[W+1:W-1]) || !(|sum_full[W+1:W-1]);
        sum_clamped = sum_ok ? sum_full[W-1:0] : (sum_full[W+1] ? WMIN : WMAX);
    end

    // ------------------------------------------------------------------
    // next values
    // ------------------------------------------------------------------
    always_comb
    begin
        pc_next     = pc_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        e_next      = e_reg;
        prey0_next  = prey0_reg;
        pred0_next  = pred0_reg;
        prey_next   = prey_reg;
        pred_next   = pred_reg;
        ar_next     = ar_reg;
        pp_next     = pp_reg;
        bpp_next    = bpp_reg;
        ebpp_next   = ebpp_reg;
        cf_next     = cf_reg;
        nprey_next  = nprey_reg;
        npred_next  = npred_reg;
        sat_next    = sat_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        mneg_next   = mneg_reg;
        acc_next    = acc_reg;
        part_next   = part_reg;
        ovalid_next = ovalid_reg;
        oprey_next  = oprey_reg;
        opred_next  = opred_reg;
        osat_next   = osat_reg;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        // config writes; indexes past the list are dropped
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ppms_pkg::CFG_GROWTH:     a_next     = cfg_data;
                ppms_pkg::CFG_INTERACT:   b_next     = cfg_data;
                ppms_pkg::CFG_DEATH:      c_next     = cfg_data;
                ppms_pkg::CFG_CONVERSION: e_next     = cfg_data;
                ppms_pkg::CFG_PREY_START: prey0_next = cfg_data;
                ppms_pkg::CFG_PRED_START: pred0_next = cfg_data;
                default: ;
            endcase
        end

        if (in_beat)
        begin
            case (s_tuser)
                ppms_pkg::KIND_STEP:
                begin
                    pc_next  = '0;
                    sat_next = 1'b0;
                end
                ppms_pkg::KIND_LOAD_START:
                begin
                    prey_next = prey0_reg;
                    pred_next = pred0_reg;
                end
                ppms_pkg::KIND_LOAD_CARRY:
                begin
                    prey_next = s_tdata[W-1:0];
                    pred_next = s_tdata[2*W-1:W];
                end
                default: ;
            endcase
        end

        if (running)
        begin
            unique case (ctrl.op)
                ppms_pkg::OP_LOAD:
                begin
                    mx_next   = (2*H)'(mag_x);
                    my_next   = (2*H)'(mag_y);
                    mneg_next = sel_x[W-1] ^ sel_y[W-1];
                    acc_next  = '0;
                    part_next = '0;
                    pc_next   = pc_reg + 1'b1;
                end
                ppms_pkg::OP_PART:
                begin
                    // signed accumulation keeps the product exact
                    acc_next  = mneg_reg ? (acc_reg - $signed(prod_sh))
                                         : (acc_reg + $signed(prod_sh));
                    part_next = part_reg + 1'b1;
                    if (ctrl.loop && part_reg != 2'd3)
                    begin
                        pc_next = ctrl.target;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                ppms_pkg::OP_FIN:
                begin
                    sat_next = sat_reg | !prod_ok;
                    unique case (ctrl.dst)
                        ppms_pkg::DST_AR:   ar_next   = prod_clamped;
                        ppms_pkg::DST_PP:   pp_next   = prod_clamped;
                        ppms_pkg::DST_BPP:  bpp_next  = prod_clamped;
                        ppms_pkg::DST_EBPP: ebpp_next = prod_clamped;
                        ppms_pkg::DST_CF:   cf_next   = prod_clamped;
                        default: ;
                    endcase
                    pc_next = pc_reg + 1'b1;
                end
                ppms_pkg::OP_SUM_PREY:
                begin
                    nprey_next = sum_clamped;
                    sat_next   = sat_reg | !sum_ok;
                    pc_next    = pc_reg + 1'b1;
                end
                ppms_pkg::OP_SUM_PRED:
                begin
                    npred_next = sum_clamped;
                    sat_next   = sat_reg | !sum_ok;
                    pc_next    = pc_reg + 1'b1;
                end
                ppms_pkg::OP_DONE:
                begin
                    // write back only once the output register is free
                    if (out_free)
                    begin
                        prey_next   = nprey_reg;
                        pred_next   = npred_reg;
                        ovalid_next = 1'b1;
                        oprey_next  = nprey_reg;
                        opred_next  = npred_reg;
                        osat_next   = sat_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // register update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ppms_pkg::SEQ_IDLE;
            pc_reg     <= '0;
            ovalid_reg <= 1'b0;
            a_reg      <= W'(ppms_pkg::GROWTH_RESET);
            b_reg      <= W'(ppms_pkg::INTERACTION_RESET);
            c_reg      <= W'(ppms_pkg::DEATH_RESET);
            e_reg      <= W'(ppms_pkg::CONVERSION_RESET);
            prey0_reg  <= W'(ppms_pkg::PREY_START_RESET);
            pred0_reg  <= W'(ppms_pkg::PRED_START_RESET);
            prey_reg   <= W'(ppms_pkg::PREY_START_RESET);
            pred_reg   <= W'(ppms_pkg::PRED_START_RESET);
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            ovalid_reg <= ovalid_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            e_reg      <= e_next;
            prey0_reg  <= prey0_next;
            pred0_reg  <= pred0_next;
            prey_reg   <= prey_next;
            pred_reg   <= pred_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        ar_reg    <= ar_next;
        pp_reg    <= pp_next;
        bpp_reg   <= bpp_next;
        ebpp_reg  <= ebpp_next;
        cf_reg    <= cf_next;
        nprey_reg <= nprey_next;
        npred_reg <= npred_next;
        sat_reg   <= sat_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        mneg_reg  <= mneg_next;
        acc_reg   <= acc_next;
        part_reg  <= part_next;
        oprey_reg <= oprey_next;
        opred_reg <= opred_next;
        osat_reg  <= osat_next;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = TDATA_W'({opred_reg, oprey_reg});
    assign m_tuser   = osat_reg;

endmodule
